/* design/smwe_pkg.sv */
// Shared constants and helper types for the sliding median block.
package smwe_pkg;

    localparam int unsigned WINDOW_DEF = 100;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned MEDIAN_W   = 17;
    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned LEN_W      = 7;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd100;

    // Control handed from the sequencer to every sorting cell.
    typedef struct packed {
        logic clear;
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

/* design/sliding_median_with_error.sv */
// Top level of the sliding-window median filter with mean deviation.
//
// Usage: each request on the s_ channel carries one tempo estimate in
// 1/16 BPM units; zero means no estimate. The block stores it in a circular
// window memory and answers with exactly one request on the m_ channel,
// holding the median of the nonzero samples among the most recent
// window_length samples (1/32 BPM), the absolute mean deviation from that
// median, and the nonzero sample count.
// The window length is written through the cfg channel while idle; the
// block itself does not enforce this, so the user must keep to it. 0 acts
// as 1 and values above WINDOW act as WINDOW.
// Steps: the memory is read and the nonzero samples are inserted into the
// sorting chain, the chain is walked to the median, then follow a multiply
// step, a 25-step serial divider with a finishing step, and an output step;
// when no sample is nonzero, the multiply and divide are skipped. One item
// is processed at a time, so a new request is taken only after the result
// has gone into the output register.
// Reset clears the fill count, write pointer and control; the sample memory
// is not cleared since entries are never read before being written.
// If the receiver stalls, the result is held in the output register while
// the next input is accepted and processed; that next result waits until
// the held one is taken.
module sliding_median_with_error #(
    parameter int unsigned WINDOW = smwe_pkg::WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] bpm_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [16:0] median_bpm, [33:17] mean_error,
                                   // [40:34] nonzero_count, [47:41] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // window_length
);

    localparam int unsigned AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CW  = $clog2(WINDOW + 1);
    localparam int unsigned SW  = smwe_pkg::SAMPLE_W;
    localparam int unsigned MW  = smwe_pkg::MEDIAN_W;
    localparam int unsigned DW  = SW + 1 + CW + 1; // diff width
    localparam int unsigned QW  = DW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [6:0]    len_cfg_reg;
    logic [CW-1:0] fill_reg;
    logic [AW-1:0] wslot_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [CW-1:0] todo_reg;
    logic          rd_pend_reg;
    logic [SW-1:0] mem [WINDOW];
    logic [SW-1:0] rd_data_reg;
    logic [CW-1:0] n_reg;
    logic [SW+CW-1:0] sum_reg;
    logic [CW-1:0] walk_reg;
    logic [MW-1:0] median_reg;
    logic [DW-1:0] diff_reg;
    logic [CW:0]   rem_reg;
    logic [$clog2(QW+1)-1:0] dcnt_reg;
    logic          m_valid_reg;
    logic [47:0]   m_data_reg;

    // Effective length clamped into 1..WINDOW and to the fill count.
    logic [CW-1:0] len_eff;
    always_comb begin
        logic [7:0] l;
        l = {1'b0, len_cfg_reg};
        if (l == 8'd0) l = 8'd1;
        if (32'(l) > WINDOW) l = 8'(WINDOW);
        len_eff = CW'(l);
        if (32'(fill_reg) + 1 < 32'(l) && fill_reg != CW'(WINDOW))
            len_eff = fill_reg + CW'(1);
    end

    // Sorting chain control.
    smwe_pkg::cell_ctl_t ctl;
    logic [SW-1:0] key;
    logic          key_ok;
    logic [WINDOW:0]      cv;
    logic [SW-1:0]        cval [WINDOW+1];
    logic [WINDOW:0]      cg;

    assign key    = rd_data_reg;
    assign key_ok = rd_pend_reg && (rd_data_reg != '0) && state_reg == ST_LOAD;
    assign ctl.clear = (state_reg == ST_IDLE);
    assign ctl.load  = key_ok;
    assign ctl.shift = 1'b0;

    assign cv[0]   = 1'b1;
    assign cval[0] = '0;
    assign cg[0]   = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_cell
            smwe_pkg::cell_ctl_t c;
            assign c.clear = ctl.clear;
            assign c.load  = ctl.load;
            assign c.shift = (gi == 0);
            smwe_cell u_cell (
                .aclk        (aclk),
                .ctl         (c),
                .key         (key),
                .left_valid  (cv[gi]),
                .left_value  (cval[gi]),
                .left_greater(cg[gi]),
                .valid       (cv[gi+1]),
                .value       (cval[gi+1]),
                .greater     (cg[gi+1])
            );
        end
    endgenerate

    // Median pick: cells walked one at a time by index.
    logic [SW-1:0] lo_reg;
    logic [SW-1:0] walk_val;
    logic [AW-1:0] walk_idx;
    assign walk_idx = AW'(walk_reg);
    always_comb begin
        walk_val = '0;
        for (int i = 0; i < WINDOW; i++)
            if (AW'(i) == walk_idx) walk_val = cval[i+1];
    end

    logic [CW-1:0] hi_idx;
    assign hi_idx = n_reg >> 1;

    logic [MW+CW-1:0] prod;
    logic [DW-1:0]    twice;
    assign twice = DW'({sum_reg, 1'b0});
    assign prod  = MW'(median_reg) * CW'(n_reg);

    logic [CW:0] rem_sh;
    assign rem_sh = {rem_reg[CW-1:0], diff_reg[DW-1]};

    // The output register takes a new result once the held one is gone.
    logic out_load;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) state_next = ST_LOAD;
            ST_LOAD: if (todo_reg == '0 && !rd_pend_reg) state_next = ST_WALK;
            ST_WALK: if (n_reg == '0) state_next = ST_OUT;
                     else if (walk_reg == hi_idx) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (dcnt_reg == '0) state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_cfg_reg <= smwe_pkg::LEN_RESET;
            fill_reg    <= '0;
            wslot_reg   <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            todo_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) len_cfg_reg <= cfg_data;
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        mem[wslot_reg] <= s_tdata;
                        todo_reg    <= len_eff;
                        rd_addr_reg <= wslot_reg;
                        wslot_reg   <= (32'(wslot_reg) == WINDOW - 1) ? '0
                                       : wslot_reg + AW'(1);
                        if (32'(fill_reg) < WINDOW) fill_reg <= fill_reg + CW'(1);
                        n_reg   <= '0;
                        sum_reg <= '0;
                    end
                end
                ST_LOAD: begin
                    if (key_ok) begin
                        n_reg   <= n_reg + CW'(1);
                        sum_reg <= sum_reg + (SW+CW)'(rd_data_reg);
                    end
                    rd_pend_reg <= (todo_reg != '0);
                    if (todo_reg != '0) begin
                        rd_data_reg <= mem[rd_addr_reg];
                        todo_reg    <= todo_reg - CW'(1);
                        rd_addr_reg <= (rd_addr_reg == '0) ? AW'(WINDOW - 1)
                                       : rd_addr_reg - AW'(1);
                    end
                    walk_reg <= '0;
                end
                ST_WALK: begin
                    if (walk_reg + CW'(1) == hi_idx) lo_reg <= walk_val;
                    if (walk_reg == hi_idx) begin
                        median_reg <= n_reg[0] ? {walk_val, 1'b0}
                                               : MW'(walk_val) + MW'(lo_reg);
                    end
                    walk_reg <= walk_reg + CW'(1);
                end
                ST_MUL: begin
                    diff_reg <= (twice >= DW'(prod)) ? twice - DW'(prod)
                                                     : DW'(prod) - twice;
                    rem_reg  <= '0;
                    dcnt_reg <= ($clog2(QW+1))'(DW);
                end
                ST_DIV: begin
                    if (dcnt_reg != '0) begin
                        if (rem_sh >= {1'b0, n_reg}) begin
                            rem_reg  <= rem_sh - {1'b0, n_reg};
                            diff_reg <= {diff_reg[DW-2:0], 1'b1};
                        end else begin
                            rem_reg  <= rem_sh;
                            diff_reg <= {diff_reg[DW-2:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - ($clog2(QW+1))'(1);
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        if (n_reg == '0) m_data_reg <= '0;
                        else m_data_reg <= {7'd0, 7'(n_reg), 17'(diff_reg), median_reg};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* design/smwe_cell.sv */
// One cell of the insertion sorting chain; holds one sample, kept ascending.
module smwe_cell (
    input  logic                            aclk,
    input  smwe_pkg::cell_ctl_t             ctl,
    input  logic [smwe_pkg::SAMPLE_W-1:0]   key,
    input  logic                            left_valid,
    input  logic [smwe_pkg::SAMPLE_W-1:0]   left_value,
    input  logic                            left_greater,
    output logic                            valid,
    output logic [smwe_pkg::SAMPLE_W-1:0]   value,
    output logic                            greater
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [smwe_pkg::SAMPLE_W-1:0] value_reg;
    logic [smwe_pkg::SAMPLE_W-1:0] value_next;

    // A valid cell whose value exceeds the key moves one place right.
    assign greater = valid_reg && (value_reg > key);

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.load) begin
            if (greater) begin
                valid_next = 1'b1;
                value_next = left_greater ? left_value : key;
            end else if (!valid_reg && (left_valid || ctl.shift)) begin
                // First empty cell takes the key, unless the left neighbor shifts in.
                if (left_greater) begin
                    valid_next = 1'b1;
                    value_next = left_value;
                end else if (!left_valid || !left_greater) begin
                    valid_next = 1'b1;
                    value_next = key;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        valid_reg <= valid_next;
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

/* verif/tb_sliding_median_with_error.sv */
// Testbench for the sliding-window median filter with mean deviation.
`timescale 1ns / 1ps

module tb_sliding_median_with_error;

    localparam int unsigned WIN = smwe_pkg::WINDOW_DEF;

    // One result of the block, unpacked from m_tdata.
    typedef struct packed {
        logic [smwe_pkg::COUNT_W-1:0]  nonzero_count;
        logic [smwe_pkg::MEDIAN_W-1:0] mean_error;
        logic [smwe_pkg::MEDIAN_W-1:0] median_bpm;
    } tempo_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] bpm_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [16:0] median_bpm, [33:17] mean_error, [40:34] nonzero_count
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;  // window_length

    sliding_median_with_error u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Predictor state: its own copy of the window memory and setting.
    logic [smwe_pkg::SAMPLE_W-1:0] tempo_window [WIN];
    int unsigned                   tempo_fill;
    int unsigned                   tempo_slot;
    logic [smwe_pkg::LEN_W-1:0]    tempo_length;

    logic [15:0]   sample_queue [$];
    tempo_result_t result_queue [$];
    int            mismatch_count;
    bit            s_taken;

    // Store one sample and compute the result it must cause.
    function automatic tempo_result_t predict_median(logic [15:0] sample);
        int unsigned   vals [WIN];
        int unsigned   len, n, total, med, key, j;
        longint        twice, scaled, dev;
        tempo_result_t res;
        tempo_window[tempo_slot] = sample;
        tempo_slot = (tempo_slot + 1) % WIN;
        if (tempo_fill < WIN) tempo_fill++;
        len = tempo_length;
        if (len < 1) len = 1;
        if (len > WIN) len = WIN;
        if (len > tempo_fill) len = tempo_fill;
        n = 0;
        total = 0;
        for (int k = 0; k < len; k++) begin
            key = tempo_window[(tempo_slot + 2 * WIN - 1 - k) % WIN];
            if (key != 0) begin
                vals[n] = key;
                total += key;
                n++;
            end
        end
        res = '0;
        if (n == 0) return res;
        // Insertion sort of the nonzero samples.
        for (int i = 1; i < n; i++) begin
            key = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > key) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = key;
        end
        // Odd count doubles the middle sample; even count sums the middle pair.
        med = n[0] ? 2 * vals[n/2] : vals[n/2] + vals[n/2-1];
        twice = 2 * longint'(total);
        scaled = longint'(n) * longint'(med);
        dev = (twice >= scaled) ? twice - scaled : scaled - twice;
        res.median_bpm = med[smwe_pkg::MEDIAN_W-1:0];
        res.mean_error = smwe_pkg::MEDIAN_W'(dev / n);
        res.nonzero_count = n[smwe_pkg::COUNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Gap length: mostly zero or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Driver: presents queued samples, with random gaps between requests.
    int unsigned send_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (s_tvalid && !s_taken) begin
            // Hold the request until it is taken.
        end else if (send_gap != 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (sample_queue.size() != 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= sample_queue.pop_front();
            send_gap <= pick_gap();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver stalls: random stretches of ready low.
    int unsigned stall_left;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // Monitor: predicts on each accepted sample and checks each result.
    always @(posedge aclk) begin
        tempo_result_t got, want;
        s_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                result_queue.push_back(predict_median(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[40:0];
                if (result_queue.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, 0);
                end else begin
                    want = result_queue.pop_front();
                    if (got.median_bpm != want.median_bpm)
                        report_mismatch("median_bpm", got.median_bpm, want.median_bpm);
                    if (got.mean_error != want.mean_error)
                        report_mismatch("mean_error", got.mean_error, want.mean_error);
                    if (got.nonzero_count != want.nonzero_count)
                        report_mismatch("nonzero_count", got.nonzero_count,
                                        want.nonzero_count);
                    if (m_tdata[47:41] != '0)
                        report_mismatch("pad bits", m_tdata[47:41], 0);
                end
            end
        end
    end

    // Wait until every queued sample is taken and every result is back.
    task automatic drain();
        while (sample_queue.size() != 0 || s_tvalid || result_queue.size() != 0)
            @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    // Write the window length while the block is idle.
    task automatic write_length(logic [6:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tempo_length = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // A run of estimates around one tempo, or fully random in about one run of four, with occasional dropouts to zero.
    task automatic queue_tempo_run(int unsigned count);
        int unsigned center, spread;
        center = $urandom_range(1, 65535);
        spread = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 64);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0)
                sample_queue.push_back(16'd0);
            else if (spread == 65535)
                sample_queue.push_back(16'($urandom_range(0, 65535)));
            else
                sample_queue.push_back(16'(center + $urandom_range(0, 2 * spread)));
        end
    endtask

    initial begin
        logic [6:0] lengths [8];
        lengths = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd100, 7'd5, 7'd99, 7'd37};
        mismatch_count = 0;
        tempo_fill     = 0;
        tempo_slot     = 0;
        tempo_length   = smwe_pkg::LEN_RESET;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: zeros before any estimate, extremes, even and odd counts,
        // all under the reset window length.
        sample_queue.push_back(16'd0);
        sample_queue.push_back(16'd0);
        sample_queue.push_back(16'hFFFF);
        sample_queue.push_back(16'd1);
        sample_queue.push_back(16'hFFFF);
        sample_queue.push_back(16'h5555);
        sample_queue.push_back(16'hAAAA);
        sample_queue.push_back(16'd0);
        sample_queue.push_back(16'd1);
        sample_queue.push_back(16'd2);
        drain();
        // Short window: zeros push every estimate out.
        write_length(7'd3);
        for (int i = 0; i < 4; i++) sample_queue.push_back(16'd0);
        sample_queue.push_back(16'd1920);
        drain();
        // Growing the window back brings older stored samples back in.
        write_length(7'd100);
        sample_queue.push_back(16'd1930);
        drain();

        // Random phases, each under its own window length.
        for (int p = 0; p < 8; p++) begin
            write_length(lengths[p]);
            repeat (4) queue_tempo_run($urandom_range(5, 15));
            drain();
        end
        write_length(7'($urandom_range(0, 127)));
        repeat (4) queue_tempo_run($urandom_range(5, 15));
        drain();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout: a bound well above what about 400 items need.
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
design/smwe_pkg.sv
design/smwe_cell.sv
design/sliding_median_with_error.sv
verif/tb_sliding_median_with_error.sv
